[design/rope_pkg.sv]
`default_nettype none

package rope_pkg;

  localparam int DEF_MAX_VECTOR      = 256;
  localparam int DEF_SAMPLE_BITS     = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 14;

  localparam int ANGLE_BITS       = 16;
  localparam int INDEX_BITS       = 8;
  localparam int TABLE_INDEX_BITS = 7;
  localparam int LENGTH_BITS      = 9;
  localparam int QUEUE_DEPTH      = 4;
  localparam int PADDR_BITS       = 3;
  localparam int PDATA_BITS       = 32;

  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 9'd128;

  typedef enum logic {
    REG_ROTATION_MODE = 1'b0,
    REG_VECTOR_LENGTH = 1'b1
  } rope_reg_e;

  typedef enum logic {
    MODE_SEPARATED   = 1'b0,
    MODE_INTERLEAVED = 1'b1
  } rope_mode_e;

  typedef enum logic {
    OP_TABLE   = 1'b0,
    OP_ELEMENT = 1'b1
  } rope_op_e;

  // Pair of result positions travelling alongside the data path
  typedef struct packed {
    logic                  valid;
    logic [INDEX_BITS-1:0] idx0;
    logic [INDEX_BITS-1:0] idx1;
  } rope_tag_t;

  typedef struct packed {
    logic ang_we;
    logic part_we;
  } rope_wr_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

[design/rope_in_if.sv]
`default_nettype none

interface rope_in_if #(
  parameter int SAMPLE_BITS = rope_pkg::DEF_SAMPLE_BITS
) ();
  import rope_pkg::*;

  logic                               valid;
  logic                               ready;
  logic                               op;
  logic        [TABLE_INDEX_BITS-1:0] table_index;
  logic signed [ANGLE_BITS-1:0]       cos_value;
  logic signed [ANGLE_BITS-1:0]       sin_value;
  logic signed [SAMPLE_BITS-1:0]      element_value;

  modport source (
    output valid, op, table_index, cos_value, sin_value, element_value,
    input  ready
  );

  modport sink (
    input  valid, op, table_index, cos_value, sin_value, element_value,
    output ready
  );

endinterface

`default_nettype wire

[design/rope_out_if.sv]
`default_nettype none

interface rope_out_if #(
  parameter int SAMPLE_BITS = rope_pkg::DEF_SAMPLE_BITS
) ();
  import rope_pkg::*;

  logic                          valid;
  logic                          ready;
  logic        [INDEX_BITS-1:0]  out_index;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic                          clipped;
  logic                          last_of_run;

  modport source (
    output valid, out_index, out_value, clipped, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_index, out_value, clipped, last_of_run,
    output ready
  );

endinterface

`default_nettype wire

[design/rope_ram.sv]
`default_nettype none

module rope_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [rope_pkg::addr_bits(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [rope_pkg::addr_bits(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/rope_seq.sv]
`default_nettype none

module rope_seq #(
  parameter int MAX_VECTOR = rope_pkg::DEF_MAX_VECTOR
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            clear_i,
  input  logic                                            accept_i,
  input  rope_pkg::rope_op_e                              op_i,
  input  logic [rope_pkg::TABLE_INDEX_BITS-1:0]           table_index_i,
  input  rope_pkg::rope_mode_e                            mode_i,
  input  logic [$clog2(MAX_VECTOR+1)-1:0]                 len_i,
  output rope_pkg::rope_wr_t                              wr_o,
  output logic [rope_pkg::addr_bits(MAX_VECTOR/2)-1:0]    ang_addr_o,
  output logic [rope_pkg::addr_bits(MAX_VECTOR/2)-1:0]    pair_addr_o,
  output rope_pkg::rope_tag_t                             tag_o
);
  import rope_pkg::*;

  localparam int TableDepth = MAX_VECTOR / 2;
  localparam int AW = addr_bits(TableDepth);
  localparam int CW = addr_bits(MAX_VECTOR);
  localparam int LW = $clog2(MAX_VECTOR + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] pos, half;
  logic          elem, wrap, first;
  logic [CW-1:0] j, p0;

  always_comb begin
    elem  = accept_i && (op_i == OP_ELEMENT);
    pos   = LW'(cnt_q);
    half  = len_i >> 1;
    wrap  = (pos + LW'(1)) == len_i;
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (elem) begin
      cnt_d = wrap ? '0 : cnt_q + CW'(1);
    end
  end

  // Work out pairing: first element of a pair is parked, second triggers the rotation
  always_comb begin
    first = 1'b0;
    j     = cnt_q;
    p0    = cnt_q;
    unique case (mode_i)
      MODE_SEPARATED: begin
        first = pos < half;
        j     = first ? cnt_q : CW'(pos - half);
        p0    = j;
      end
      MODE_INTERLEAVED: begin
        first = ~cnt_q[0];
        j     = cnt_q >> 1;
        p0    = cnt_q & ~CW'(1);
      end
    endcase
  end

  always_comb begin
    wr_o.ang_we  = accept_i && (op_i == OP_TABLE) && (int'(table_index_i) < TableDepth);
    wr_o.part_we = elem && first;
    tag_o.valid  = elem && !first;
    tag_o.idx0   = INDEX_BITS'(p0);
    tag_o.idx1   = INDEX_BITS'(cnt_q);
    ang_addr_o   = AW'(table_index_i);
    pair_addr_o  = AW'(j);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/rope_math.sv]
`default_nettype none

module rope_math #(
  parameter int SAMPLE_BITS     = rope_pkg::DEF_SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = rope_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  rope_pkg::rope_tag_t                       tag_i,
  input  logic signed [SAMPLE_BITS-1:0]             a_i,
  input  logic signed [SAMPLE_BITS-1:0]             b_i,
  input  logic signed [rope_pkg::ANGLE_BITS-1:0]    c_i,
  input  logic signed [rope_pkg::ANGLE_BITS-1:0]    s_i,
  output rope_pkg::rope_tag_t                       tag_o,
  output logic signed [SAMPLE_BITS-1:0]             val0_o,
  output logic                                      clip0_o,
  output logic signed [SAMPLE_BITS-1:0]             val1_o,
  output logic                                      clip1_o
);
  import rope_pkg::*;

  localparam int PW = SAMPLE_BITS + ANGLE_BITS;
  localparam int RW = ((PW > ANGLE_FRAC_BITS) ? PW : ANGLE_FRAC_BITS) + 2;
  localparam int SW = RW + 1;
  localparam logic signed [RW-1:0] RND_HALF = RW'(1) <<< (ANGLE_FRAC_BITS - 1);

  rope_tag_t             tag_q;
  logic signed [PW-1:0]  ac_q, bs_q, bc_q, as_q;
  logic signed [SW-1:0]  sum0, sum1;

  // Round to nearest, ties upward, then drop the fraction bits
  function automatic logic signed [RW-1:0] round_prod(input logic signed [PW-1:0] p);
    logic signed [RW-1:0] w;
    w = RW'(p) + RND_HALF;
    return w >>> ANGLE_FRAC_BITS;
  endfunction

  function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [SW-1:0] v);
    logic [SW-SAMPLE_BITS:0] upper;
    upper = v[SW-1:SAMPLE_BITS-1];
    if ((&upper) || !(|upper)) begin
      return {1'b0, v[SAMPLE_BITS-1:0]};
    end else if (v[SW-1]) begin
      return {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q <= PW'(a_i * c_i);
    bs_q <= PW'(b_i * s_i);
    bc_q <= PW'(b_i * c_i);
    as_q <= PW'(a_i * s_i);
  end

  always_comb begin
    sum0 = SW'(round_prod(ac_q)) - SW'(round_prod(bs_q));
    sum1 = SW'(round_prod(bc_q)) + SW'(round_prod(as_q));
    {clip0_o, val0_o} = saturate(sum0);
    {clip1_o, val1_o} = saturate(sum1);
    tag_o = tag_q;
  end

endmodule

`default_nettype wire

[design/rope_outq.sv]
`default_nettype none

module rope_outq #(
  parameter int SAMPLE_BITS = rope_pkg::DEF_SAMPLE_BITS,
  parameter int DEPTH       = rope_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  rope_pkg::rope_tag_t                  tag_i,
  input  logic signed [SAMPLE_BITS-1:0]        val0_i,
  input  logic                                 clip0_i,
  input  logic signed [SAMPLE_BITS-1:0]        val1_i,
  input  logic                                 clip1_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [rope_pkg::INDEX_BITS-1:0]      index_o,
  output logic signed [SAMPLE_BITS-1:0]        value_o,
  output logic                                 clipped_o,
  output logic                                 last_o,
  output logic [$clog2(DEPTH+1)-1:0]           count_o
);
  import rope_pkg::*;

  localparam int PTRW = addr_bits(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic        [INDEX_BITS-1:0]  idx0_q  [DEPTH];
  logic        [INDEX_BITS-1:0]  idx1_q  [DEPTH];
  logic signed [SAMPLE_BITS-1:0] val0_q  [DEPTH];
  logic signed [SAMPLE_BITS-1:0] val1_q  [DEPTH];
  logic                          clip0_q [DEPTH];
  logic                          clip1_q [DEPTH];

  logic [PTRW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            sel_q, sel_d;
  logic            take, pop;

  function automatic logic [PTRW-1:0] bump(input logic [PTRW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + PTRW'(1);
  endfunction

  always_comb begin
    valid_o = cnt_q != '0;
    take    = valid_o && ready_i;
    pop     = take && sel_q;
    wr_d    = push_i ? bump(wr_q) : wr_q;
    rd_d    = pop ? bump(rd_q) : rd_q;
    cnt_d   = cnt_q + CNTW'(push_i) - CNTW'(pop);
    sel_d   = take ? ~sel_q : sel_q;
  end

  // Each entry holds both results of a pair; sel picks the first or second
  always_comb begin
    index_o   = sel_q ? idx1_q[rd_q]  : idx0_q[rd_q];
    value_o   = sel_q ? val1_q[rd_q]  : val0_q[rd_q];
    clipped_o = sel_q ? clip1_q[rd_q] : clip0_q[rd_q];
    last_o    = sel_q;
    count_o   = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sel_q <= 1'b0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      idx0_q[wr_q]  <= tag_i.idx0;
      idx1_q[wr_q]  <= tag_i.idx1;
      val0_q[wr_q]  <= val0_i;
      val1_q[wr_q]  <= val1_i;
      clip0_q[wr_q] <= clip0_i;
      clip1_q[wr_q] <= clip1_i;
    end
  end

endmodule

`default_nettype wire

[design/rotary_position_embedding.sv]
// Rotary position embedding over a stream of head-vector elements.
// Input channel in_i carries two kinds of request: op 0 loads one cos/sin
// entry of the angle table, op 1 delivers the next element of a head vector.
// Elements are counted modulo the configured vector length. The first element
// of each pair is parked in the partner RAM; the second reads the partner and
// the angle entry and yields two results on out_o, the first-position result
// and then the second, flagged by last_of_run.
// A pair-completing element passes the RAM read, the multiply register and
// round/saturate into the queue. Throughput: one request per cycle while
// in_i.ready is high, one result per cycle while out_o.ready is high.
// Results wait in a four-pair queue; ready on in_i falls while in-flight pairs
// plus queued pairs reach four, so a stalled receiver holds the input off
// without loss. Table loads and first elements also wait on that credit.
// Configuration through the APB port: rotation_mode at 0x0, vector_length at
// 0x4. Any write restarts the element count. Write only while idle.
// Reset clears the counter, queue and registers (mode separated, length 128);
// the angle and partner RAMs are not cleared and no sweep runs after reset.
`default_nettype none

module rotary_position_embedding #(
  parameter int MAX_VECTOR      = rope_pkg::DEF_MAX_VECTOR,
  parameter int SAMPLE_BITS     = rope_pkg::DEF_SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = rope_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rope_in_if.sink                             in_i,
  rope_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rope_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [rope_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [rope_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready
);
  import rope_pkg::*;

  localparam int TableDepth = MAX_VECTOR / 2;
  localparam int AW   = addr_bits(TableDepth);
  localparam int LW   = $clog2(MAX_VECTOR + 1);
  localparam int VW   = (LW > LENGTH_BITS) ? LW : LENGTH_BITS;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PCW  = QCW + 1;

  // Configuration
  rope_mode_e             mode_q, mode_d;
  logic [LENGTH_BITS-1:0] vl_q, vl_d;
  logic                   cfg_we;
  logic [VW-1:0]          len_raw, len_full;
  logic [LW-1:0]          len;

  always_comb begin
    cfg_we = psel && penable && pwrite;
    mode_d = mode_q;
    vl_d   = vl_q;
    if (cfg_we) begin
      unique case (rope_reg_e'(paddr[2]))
        REG_ROTATION_MODE: mode_d = rope_mode_e'(pwdata[0]);
        REG_VECTOR_LENGTH: vl_d   = pwdata[LENGTH_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (rope_reg_e'(paddr[2]))
      REG_ROTATION_MODE: prdata = PDATA_BITS'(mode_q);
      REG_VECTOR_LENGTH: prdata = PDATA_BITS'(vl_q);
    endcase
    pready = 1'b1;
  end

  // Drop the lowest bit, clamp to two and the vector maximum
  always_comb begin
    len_raw = VW'({vl_q[LENGTH_BITS-1:1], 1'b0});
    if (len_raw < VW'(2)) begin
      len_full = VW'(2);
    end else if (len_raw > VW'(MAX_VECTOR)) begin
      len_full = VW'(MAX_VECTOR);
    end else begin
      len_full = len_raw;
    end
    len = LW'(len_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEPARATED;
      vl_q   <= LENGTH_RESET;
    end else begin
      mode_q <= mode_d;
      vl_q   <= vl_d;
    end
  end

  // Request side
  logic                 in_acc;
  rope_wr_t             wr;
  rope_tag_t            seq_tag, s1_tag_q, m_tag;
  logic [AW-1:0]        ang_addr, pair_addr;
  logic [PCW-1:0]       pending;
  logic [QCW-1:0]       q_count;

  assign in_acc = in_i.valid && in_i.ready;

  rope_seq #(
    .MAX_VECTOR (MAX_VECTOR)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we),
    .accept_i      (in_acc),
    .op_i          (rope_op_e'(in_i.op)),
    .table_index_i (in_i.table_index),
    .mode_i        (mode_q),
    .len_i         (len),
    .wr_o          (wr),
    .ang_addr_o    (ang_addr),
    .pair_addr_o   (pair_addr),
    .tag_o         (seq_tag)
  );

  logic [2*ANGLE_BITS-1:0]       ang_rdata;
  logic [SAMPLE_BITS-1:0]        part_rdata;
  logic signed [SAMPLE_BITS-1:0] s1_b_q;

  rope_ram #(
    .WIDTH (2 * ANGLE_BITS),
    .DEPTH (TableDepth)
  ) u_angle_ram (
    .clk_i   (clk_i),
    .we_i    (wr.ang_we),
    .waddr_i (ang_addr),
    .wdata_i ({in_i.cos_value, in_i.sin_value}),
    .raddr_i (pair_addr),
    .rdata_o (ang_rdata)
  );

  rope_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TableDepth)
  ) u_partner_ram (
    .clk_i   (clk_i),
    .we_i    (wr.part_we),
    .waddr_i (pair_addr),
    .wdata_i (in_i.element_value),
    .raddr_i (pair_addr),
    .rdata_o (part_rdata)
  );

  // Align the second element with the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else begin
      s1_tag_q <= seq_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_b_q <= in_i.element_value;
  end

  logic signed [SAMPLE_BITS-1:0] val0, val1;
  logic                          clip0, clip1;

  rope_math #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (s1_tag_q),
    .a_i     (signed'(part_rdata)),
    .b_i     (s1_b_q),
    .c_i     (signed'(ang_rdata[2*ANGLE_BITS-1:ANGLE_BITS])),
    .s_i     (signed'(ang_rdata[ANGLE_BITS-1:0])),
    .tag_o   (m_tag),
    .val0_o  (val0),
    .clip0_o (clip0),
    .val1_o  (val1),
    .clip1_o (clip1)
  );

  rope_outq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (QUEUE_DEPTH)
  ) u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (m_tag.valid),
    .tag_i     (m_tag),
    .val0_i    (val0),
    .clip0_i   (clip0),
    .val1_i    (val1),
    .clip1_i   (clip1),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .index_o   (out_o.out_index),
    .value_o   (out_o.out_value),
    .clipped_o (out_o.clipped),
    .last_o    (out_o.last_of_run),
    .count_o   (q_count)
  );

  // Credit: pairs in the pipeline plus pairs queued never exceed the queue
  assign pending    = PCW'(s1_tag_q.valid) + PCW'(m_tag.valid) + PCW'(q_count);
  assign in_i.ready = pending < PCW'(QUEUE_DEPTH);

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= PCW'(QUEUE_DEPTH))
    else $error("pairs in flight exceed queue space");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tag.valid |-> q_count < QCW'(QUEUE_DEPTH))
    else $error("result pair pushed into a full queue");

  a_pair_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_tag_q.valid |-> $past(in_acc && (in_i.op == OP_ELEMENT)))
    else $error("pair read without an accepted element");

endmodule

`default_nettype wire

[sim/tb_rotary_position_embedding.sv]
module tb_rotary_position_embedding;
  import rope_pkg::*;

  localparam int     TABLE_DEPTH   = DEF_MAX_VECTOR / 2;
  localparam int     TOTAL_ITEMS   = 500;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     QUIET_LIMIT   = 5000;
  localparam longint SAMPLE_MAX    = (longint'(1) <<< (DEF_SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;
  localparam longint ROUND_HALF    = longint'(1) <<< (DEF_ANGLE_FRAC_BITS - 1);

  typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ANGLE_BITS-1:0]      angle_t;
  typedef logic [TABLE_INDEX_BITS-1:0]       entry_t;

  typedef struct {
    rope_op_e op;
    entry_t   index;
    angle_t   cos_v;
    angle_t   sin_v;
    sample_t  elem;
  } request_t;

  typedef struct {
    logic [INDEX_BITS-1:0] index;
    sample_t               value;
    logic                  clipped;
    logic                  last;
  } rotated_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  rope_in_if  in_if ();
  rope_out_if out_if ();

  rotary_position_embedding dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the rotation unit
  angle_t                cos_shadow    [TABLE_DEPTH];
  angle_t                sin_shadow    [TABLE_DEPTH];
  sample_t               partner_shadow[TABLE_DEPTH];
  bit                    angle_written [TABLE_DEPTH];
  int unsigned           elem_pos;
  rope_mode_e            mode_shadow;
  logic [LENGTH_BITS-1:0] length_shadow;

  rotated_t expected_results[$];

  int error_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int max_burst   = 1;
  int max_gap     = 0;
  int stall_pct   = 0;
  int max_hold    = 0;
  int hold_left   = 0;

  function automatic int unsigned active_length();
    int unsigned len;
    len = {length_shadow[LENGTH_BITS-1:1], 1'b0};
    if (len < 2) len = 2;
    if (len > DEF_MAX_VECTOR) len = DEF_MAX_VECTOR;
    return len;
  endfunction

  function automatic int unsigned next_angle_entry();
    int unsigned len;
    int unsigned p;
    len = active_length();
    p = (elem_pos >= len) ? 0 : elem_pos;
    if (mode_shadow == MODE_INTERLEAVED) return p / 2;
    return (p < len / 2) ? p : p - len / 2;
  endfunction

  function automatic longint scale_product(longint x, longint y);
    return (x * y + ROUND_HALF) >>> DEF_ANGLE_FRAC_BITS;
  endfunction

  function automatic void push_rotation(int unsigned pos, longint v, logic last);
    rotated_t r;
    r.clipped = 1'b0;
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
      r.clipped = 1'b1;
    end
    if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.index = pos[INDEX_BITS-1:0];
    r.value = sample_t'(v);
    r.last  = last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void rotate_element(sample_t b);
    int unsigned len;
    int unsigned half;
    int unsigned p;
    int unsigned j;
    int unsigned p0;
    longint      a;
    longint      c;
    longint      s;
    longint      bl;
    len  = active_length();
    half = len / 2;
    if (elem_pos >= len) elem_pos = 0;
    p = elem_pos;
    elem_pos = (p + 1 >= len) ? 0 : p + 1;
    if (mode_shadow == MODE_SEPARATED) begin
      if (p < half) begin
        partner_shadow[p] = b;
        return;
      end
      j  = p - half;
      p0 = j;
    end else begin
      j = p / 2;
      if (p % 2 == 0) begin
        partner_shadow[j] = b;
        return;
      end
      p0 = p - 1;
    end
    a  = longint'(partner_shadow[j]);
    c  = longint'(cos_shadow[j]);
    s  = longint'(sin_shadow[j]);
    bl = longint'(b);
    push_rotation(p0, scale_product(a, c) - scale_product(bl, s), 1'b0);
    push_rotation(p, scale_product(bl, c) + scale_product(a, s), 1'b1);
  endfunction

  function automatic void apply_request(request_t rq);
    if (rq.op == OP_TABLE) begin
      cos_shadow[rq.index]    = rq.cos_v;
      sin_shadow[rq.index]    = rq.sin_v;
      angle_written[rq.index] = 1'b1;
    end else begin
      rotate_element(rq.elem);
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 1023)) - 512);
      2: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(SAMPLE_MAX);
          1: return sample_t'(SAMPLE_MIN);
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      default: return sample_t'(int'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 3))
      0: return angle_t'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? angle_t'(SAMPLE_MAX) : angle_t'(SAMPLE_MIN);
      default: return angle_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic void pick_flow_profile();
    case ($urandom_range(0, 3))
      0: begin
        max_gap   = 0;
        stall_pct = 0;
      end
      1: begin
        max_gap   = $urandom_range(1, 6);
        stall_pct = 0;
      end
      2: begin
        max_gap   = 0;
        stall_pct = $urandom_range(20, 70);
      end
      default: begin
        max_gap   = $urandom_range(1, 6);
        stall_pct = $urandom_range(20, 70);
      end
    endcase
    max_burst = $urandom_range(1, 8);
    max_hold  = $urandom_range(0, 12);
  endfunction

  // Receiver: hold ready for a random stretch, then pick again
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= stall_pct);
      hold_left    = $urandom_range(0, max_hold);
    end
  end

  always @(posedge clk_i) begin : check_results
    rotated_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_index %0d out_value %0d",
               out_if.out_index, out_if.out_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.out_index !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_if.out_index);
          error_count++;
        end
        if (out_if.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_if.out_value);
          error_count++;
        end
        if (out_if.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_if.clipped);
          error_count++;
        end
        if (out_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_if.last_of_run);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, max_burst);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.op            = rq.op;
    in_if.table_index   = rq.index;
    in_if.cos_value     = rq.cos_v;
    in_if.sin_value     = rq.sin_v;
    in_if.element_value = rq.elem;
    in_if.valid         = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_request(rq);
    items_sent++;
  endtask

  task automatic send_table(input int unsigned idx, input angle_t c, input angle_t s);
    request_t rq;
    rq.op    = OP_TABLE;
    rq.index = entry_t'(idx);
    rq.cos_v = c;
    rq.sin_v = s;
    rq.elem  = sample_t'($urandom);
    send_request(rq);
  endtask

  task automatic send_element(input sample_t v);
    request_t    rq;
    int unsigned entry;
    // load the angle entry first if it has never been written
    entry = next_angle_entry();
    if (!angle_written[entry]) send_table(entry, rand_angle(), rand_angle());
    rq.op    = OP_ELEMENT;
    rq.index = entry_t'($urandom);
    rq.cos_v = angle_t'($urandom);
    rq.sin_v = angle_t'($urandom);
    rq.elem  = v;
    send_request(rq);
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rope_reg_e sel, input logic [PDATA_BITS-1:0] data);
    wait_for_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (sel)
      REG_ROTATION_MODE: mode_shadow = rope_mode_e'(data[0]);
      REG_VECTOR_LENGTH: length_shadow = data[LENGTH_BITS-1:0];
      default: ;
    endcase
    elem_pos = 0;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic test_saturation();
    write_reg(REG_ROTATION_MODE, PDATA_BITS'(MODE_SEPARATED));
    write_reg(REG_VECTOR_LENGTH, 4);
    send_table(0, angle_t'(SAMPLE_MAX), angle_t'(SAMPLE_MIN));
    send_table(1, angle_t'(SAMPLE_MIN), angle_t'(SAMPLE_MAX));
    send_element(sample_t'(SAMPLE_MAX));
    send_element(sample_t'(SAMPLE_MIN));
    send_element(sample_t'(SAMPLE_MIN));
    send_element(sample_t'(SAMPLE_MAX));
  endtask

  // Half-way products exercise the round-half-up step; length zero clamps to two
  task automatic test_rounding();
    write_reg(REG_VECTOR_LENGTH, 0);
    send_table(0, angle_t'(8192), angle_t'(-8192));
    send_element(sample_t'(1));
    send_element(sample_t'(-1));
    send_element(sample_t'(-1));
    send_element(sample_t'(1));
    send_element(sample_t'(3));
    send_element(sample_t'(-3));
  endtask

  task automatic test_interleaved();
    write_reg(REG_ROTATION_MODE, PDATA_BITS'(MODE_INTERLEAVED));
    write_reg(REG_VECTOR_LENGTH, 6);
    send_table(2, angle_t'(16384), angle_t'(0));
    send_element(sample_t'(0));
    send_element(sample_t'(16384));
    send_element(sample_t'(-1));
    send_element(sample_t'(SAMPLE_MAX));
    send_element(sample_t'(SAMPLE_MIN));
    send_element(sample_t'(1));
  endtask

  // Drop a half-finished vector: a register write restarts the count
  task automatic test_restart();
    write_reg(REG_ROTATION_MODE, PDATA_BITS'(MODE_SEPARATED));
    write_reg(REG_VECTOR_LENGTH, 5);
    send_element(rand_sample());
    send_element(rand_sample());
    write_reg(REG_VECTOR_LENGTH, 5);
    repeat (4) send_element(rand_sample());
  endtask

  task automatic test_full_length();
    write_reg(REG_VECTOR_LENGTH, 511);
    pick_flow_profile();
    repeat (DEF_MAX_VECTOR) send_element(rand_sample());
  endtask

  task automatic test_random_traffic();
    int                     nvec;
    int unsigned            len;
    logic [PDATA_BITS-1:0]  data;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        data    = $urandom;
        data[0] = rope_mode_e'($urandom_range(0, 1));
        write_reg(REG_ROTATION_MODE, data);
        data = $urandom;
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 3))
            0: data[LENGTH_BITS-1:0] = 255;
            1: data[LENGTH_BITS-1:0] = 256;
            2: data[LENGTH_BITS-1:0] = 257;
            default: data[LENGTH_BITS-1:0] = 511;
          endcase
        end else begin
          data[LENGTH_BITS-1:0] = $urandom_range(0, 40);
        end
        write_reg(REG_VECTOR_LENGTH, data);
      end
      pick_flow_profile();
      len = active_length();
      repeat ($urandom_range(0, 4))
        send_table($urandom_range(0, len / 2 - 1), rand_angle(), rand_angle());
      nvec = (len > 64) ? 1 : $urandom_range(1, 3);
      repeat (nvec * len) send_element(rand_sample());
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, len - 1)) send_element(rand_sample());
        1: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 1)
              send_table($urandom_range(0, TABLE_DEPTH - 1), rand_angle(), rand_angle());
            else
              send_element(rand_sample());
          end
        end
        default: ;
      endcase
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.op             = OP_TABLE;
    in_if.table_index    = '0;
    in_if.cos_value      = '0;
    in_if.sin_value      = '0;
    in_if.element_value  = '0;
    out_if.ready         = 1'b0;
    elem_pos             = 0;
    mode_shadow          = MODE_SEPARATED;
    length_shadow        = LENGTH_RESET;
    foreach (angle_written[i]) angle_written[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_saturation();
    test_rounding();
    test_interleaved();
    test_restart();
    test_full_length();
    test_random_traffic();
    wait_for_idle();

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
